### hdl/assert_macros.svh
// Assertion macros shared by the codec RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

### hdl/bch_pkg.sv
// Types, constants and GF(32) helpers for the BCH(31,16) codec
`default_nettype none
package bch_pkg;

   localparam int N_BITS = 31;
   localparam int K_BITS = 16;
   localparam int P_BITS = 15;
   localparam logic [15:0] GEN_POLY = 16'h8FAF;

   typedef logic [4:0] gf_type;

   typedef enum logic {
      OP_ENCODE = 1'b0,
      OP_DECODE = 1'b1
   } op_type;

   // item carried through the queue and the back stages
   typedef struct packed {
      op_type      op;
      logic [15:0] msg;
      logic [30:0] word;
   } item_type;

   // GF(32) multiply, primitive polynomial x^5+x^2+1
   function automatic gf_type gf_mul(input gf_type a, input gf_type b);
      gf_type r;
      gf_type t;
      r = '0;
      t = a;
      for (int i = 0; i < 5; i++) begin
         if (b[i]) r = r ^ t;
         t = t[4] ? ({t[3:0], 1'b0} ^ 5'h05) : {t[3:0], 1'b0};
      end
      return r;
   endfunction

   // alpha^e for e in 0..30
   function automatic gf_type gf_pow(input int e);
      gf_type r;
      r = 5'd1;
      for (int i = 0; i < e; i++) r = gf_mul(r, 5'd2);
      return r;
   endfunction

   // inverse by constant table lookup (a^30)
   function automatic gf_type gf_inv(input gf_type a);
      gf_type r;
      r = '0;
      for (int k = 0; k < 31; k++) begin
         if (gf_pow(k) == a) r = gf_pow((31 - k) % 31);
      end
      return r;
   endfunction

   // syndrome r(alpha^j): xor of alpha^(j*i) over set bits
   function automatic gf_type syndrome(input logic [30:0] w, input int j);
      gf_type acc;
      acc = '0;
      for (int i = 0; i < 31; i++) begin
         if (w[i]) acc = acc ^ gf_pow((j * i) % 31);
      end
      return acc;
   endfunction

endpackage
`default_nettype wire

### hdl/bch_front.sv
// Front end: input beat capture, encode parity, decode syndromes
`default_nettype none
module bch_front import bch_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire item_type    in_item,
   output logic             out_valid,
   input  wire logic        out_ready,
   output item_type         out_item,
   output gf_type [5:0]     out_syn,
   output logic [14:0]      out_par
);

   logic         valid_ff, valid_in;
   item_type     item_ff;
   gf_type [5:0] syn_ff, syn_in;
   logic [14:0]  par_ff, par_in;
   logic [30:0]  rem;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // parity by long division, unrolled over the message bits; syndromes S1..S6 of the word
   always_comb begin
      rem = {in_item.msg, 15'd0};
      for (int b = 30; b >= 15; b--) begin
         if (rem[b]) rem = rem ^ (31'(GEN_POLY) << (b - 15));
      end
      par_in = rem[14:0];
      for (int j = 0; j < 6; j++) syn_in[j] = syndrome(in_item.word, j + 1);
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      if (in_ready && in_valid) begin
         item_ff <= in_item;
         syn_ff  <= syn_in;
         par_ff  <= par_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
   assign out_syn   = syn_ff;
   assign out_par   = par_ff;

endmodule
`default_nettype wire

### hdl/bch_queue.sv
// Two-entry queue between front and back
`default_nettype none
module bch_queue import bch_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire item_type    in_item,
   input  wire gf_type [5:0] in_syn,
   input  wire logic [14:0] in_par,
   output logic             out_valid,
   input  wire logic        out_ready,
   output item_type         out_item,
   output gf_type [5:0]     out_syn,
   output logic [14:0]      out_par
);

   localparam int W = $bits(item_type) + 30 + 15;

   logic [W-1:0] mem_ff [2];
   logic         wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;
   assign wp_in  = push ? !wp_ff : wp_ff;
   assign rp_in  = pop ? !rp_ff : rp_ff;
   assign cnt_in = cnt_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= {in_item, in_syn, in_par};
   end

   assign {out_item, out_syn, out_par} = mem_ff[rp_ff];

   `include "assert_macros.svh"
   `ASSERT_IMPLY(a_no_overflow, clock, reset, cnt_ff == 2'd2, !push)
   `ASSERT_NEXT(a_pop_count, clock, reset, pop && !push, cnt_ff == $past(cnt_ff) - 2'd1)

endmodule
`default_nettype wire

### hdl/bch_back.sv
// Back end: Berlekamp iterations in stages, then Chien search and output register
`default_nettype none
module bch_back import bch_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire item_type     in_item,
   input  wire gf_type [5:0] in_syn,
   input  wire logic [14:0]  in_par,
   output logic              out_valid,
   input  wire logic         out_ready,
   output logic [30:0]       out_codeword,
   output logic [15:0]       out_message
);

   // stage 0..2 Berlekamp, stage 3 Chien/output
   logic             v_ff [4];
   item_type         it_ff [3];
   gf_type [5:0]     s_ff [3];
   logic [14:0]      p_ff [3];
   gf_type [7:0]     lam_ff [3];
   gf_type [7:0]     tp_ff [3];
   logic [30:0]      cw_ff;
   logic [15:0]      dm_ff;
   logic             adv [4];

   gf_type [7:0]     lam_in [3];
   gf_type [7:0]     tp_in [3];
   gf_type [7:0]     lam_src [3];
   gf_type [7:0]     tp_src [3];
   gf_type [6:0]     syn_src [3];
   logic [30:0]      cw_in;
   logic [15:0]      dm_in;

   // stall chain from the output back
   assign adv[3] = !v_ff[3] || out_ready;
   assign adv[2] = !v_ff[2] || adv[3];
   assign adv[1] = !v_ff[1] || adv[2];
   assign adv[0] = !v_ff[0] || adv[1];
   assign in_ready = adv[0];

   // one Berlekamp iteration per stage
   always_comb begin
      for (int s = 0; s < 3; s++) begin
         gf_type d;
         gf_type di;
         int     deg;
         if (s == 0) begin
            lam_src[s] = 40'd1;
            tp_src[s]  = 40'd1;
            syn_src[s] = {in_syn, 5'd1};
         end else begin
            lam_src[s] = lam_ff[s-1];
            tp_src[s]  = tp_ff[s-1];
            syn_src[s] = {s_ff[s-1], 5'd1};
         end
         d = '0;
         for (int i = 0; i <= 2 * s + 1; i++)
            d = d ^ gf_mul(lam_src[s][i], syn_src[s][2 * s + 1 - i]);
         lam_in[s][0] = lam_src[s][0];
         for (int i = 1; i < 8; i++)
            lam_in[s][i] = lam_src[s][i] ^ gf_mul(d, tp_src[s][i-1]);
         deg = 0;
         for (int i = 1; i < 8; i++) if (lam_src[s][i] != 0) deg = i;
         di = gf_inv(d);
         tp_in[s][0] = '0;
         if (d == 0 || deg > s) begin
            tp_in[s][1] = '0;
            for (int i = 2; i < 8; i++) tp_in[s][i] = tp_src[s][i-2];
         end else begin
            for (int i = 1; i < 8; i++) tp_in[s][i] = gf_mul(lam_src[s][i-1], di);
         end
      end
   end

   // Chien search over all 31 positions, plus result select
   always_comb begin
      logic [30:0] w;
      w = it_ff[2].word;
      for (int p = 0; p < 31; p++) begin
         gf_type acc;
         acc = '0;
         for (int i = 0; i < 8; i++)
            acc = acc ^ gf_mul(lam_ff[2][i], gf_pow((i * (31 - p)) % 31));
         if (acc == 0) w[p] = !w[p];
      end
      if (it_ff[2].op == OP_DECODE) begin
         cw_in = '0;
         dm_in = w[30:15];
      end else begin
         cw_in = {it_ff[2].msg, p_ff[2]};
         dm_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 4; s++) v_ff[s] <= 1'b0;
      end else begin
         if (adv[0]) v_ff[0] <= in_valid;
         for (int s = 1; s < 4; s++) if (adv[s]) v_ff[s] <= v_ff[s-1];
      end
      if (adv[0]) begin
         it_ff[0] <= in_item; s_ff[0] <= in_syn; p_ff[0] <= in_par;
         lam_ff[0] <= lam_in[0]; tp_ff[0] <= tp_in[0];
      end
      for (int s = 1; s < 3; s++) begin
         if (adv[s]) begin
            it_ff[s] <= it_ff[s-1]; s_ff[s] <= s_ff[s-1]; p_ff[s] <= p_ff[s-1];
            lam_ff[s] <= lam_in[s]; tp_ff[s] <= tp_in[s];
         end
      end
      if (adv[3]) begin
         cw_ff <= cw_in; dm_ff <= dm_in;
      end
   end

   assign out_valid    = v_ff[3];
   assign out_codeword = cw_ff;
   assign out_message  = dm_ff;

   `include "assert_macros.svh"
   `ASSERT_NEXT(a_hold, clock, reset, v_ff[3] && !out_ready, v_ff[3] && $stable(cw_ff))
   `ASSERT_IMPLY(a_one_field, clock, reset, v_ff[3], cw_ff == 31'd0 || dm_ff == 16'd0)

endmodule
`default_nettype wire

### hdl/bch_31_16_codec_unit.sv
// Top level of the BCH(31,16) three-error codec
//  channel | direction | beat fields
//  req_    | in        | operation, message, received_word
//  rsp_    | out       | codeword, decoded_message
// One beat per cycle sustained while rsp_ready stays high; rsp_valid follows the req_ accept
// through the front register, queue entry, three Berlekamp stages and Chien/output stage.
// Synchronous reset empties the queue and all stages.
// A stalled rsp_ fills the back stages, then the queue, then the front register, then drops req_ready.
`default_nettype none
module bch_31_16_codec_unit import bch_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_operation,
   input  wire logic [15:0] req_message,
   input  wire logic [30:0] req_received_word,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [30:0]      rsp_codeword,
   output logic [15:0]      rsp_decoded_message
);

   item_type     req_item, f_item, q_item;
   gf_type [5:0] f_syn, q_syn;
   logic [14:0]  f_par, q_par;
   logic         f_valid, f_ready, q_valid, q_ready;

   assign req_item.op   = op_type'(req_operation);
   assign req_item.msg  = req_message;
   assign req_item.word = req_received_word;

   bch_front u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_ready(req_ready), .in_item(req_item),
      .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item),
      .out_syn(f_syn), .out_par(f_par)
   );

   bch_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
      .in_syn(f_syn), .in_par(f_par),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item),
      .out_syn(q_syn), .out_par(q_par)
   );

   bch_back u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
      .in_syn(q_syn), .in_par(q_par),
      .out_valid(rsp_valid), .out_ready(rsp_ready),
      .out_codeword(rsp_codeword), .out_message(rsp_decoded_message)
   );

endmodule
`default_nettype wire
